// ----- design/lea_pkg.sv -----
`timescale 1ns / 1ps

package lea_pkg;

   localparam int COL_W = 4;
   localparam int STEP_W = 3;
   localparam int DUR_W = 16;
   localparam int TIME_W = 32;
   localparam int CSR_INDEX_W = 3;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [STEP_W-1:0] step_type;
   typedef logic [DUR_W-1:0] dur_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [7:0] pixels_type;

   localparam col_type LAST_COL = 4'd13;
   localparam col_type EYE_COLS = 4'd7;

   localparam step_type BLINK_LEN = 3'd5;
   localparam step_type LOOK_STEPS = 3'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LONG_OPEN    = 3'd0,
      REG_BLINK_CLOSED = 3'd1,
      REG_SHORT_OPEN   = 3'd2,
      REG_LOOK_HOLD    = 3'd3,
      REG_CENTER_HOLD  = 3'd4
   } csr_index_type;

   localparam dur_type LONG_OPEN_RESET    = 16'd2000;
   localparam dur_type BLINK_CLOSED_RESET = 16'd100;
   localparam dur_type SHORT_OPEN_RESET   = 16'd150;
   localparam dur_type LOOK_HOLD_RESET    = 16'd500;
   localparam dur_type CENTER_HOLD_RESET  = 16'd200;

   localparam pixels_type CLOSED_BITS = 8'h08;
   localparam pixels_type PUPIL_UP    = 8'h0E;
   localparam pixels_type PUPIL_MID   = 8'h38;

   function automatic pixels_type oval_bits(input logic [2:0] e);
      pixels_type b;
      case (e)
         3'd0, 3'd6: b = 8'h3C;
         3'd1, 3'd5: b = 8'h42;
         default:    b = 8'h81;
      endcase
      return b;
   endfunction

   function automatic pixels_type column_pattern(input logic link, input step_type step,
                                                 input col_type col);
      col_type    e4;
      logic [2:0] e;
      logic [2:0] pc;
      pixels_type pat;
      pixels_type b;
      e4 = (col < EYE_COLS) ? col : col - EYE_COLS;
      e = e4[2:0];
      case (step[1:0])
         2'd0: begin
            pc = 3'd1;
            pat = PUPIL_UP;
         end
         2'd2: begin
            pc = 3'd4;
            pat = PUPIL_UP;
         end
         default: begin
            pc = 3'd2;
            pat = PUPIL_MID;
         end
      endcase
      if (!link && (step == 3'd1 || step == 3'd3)) begin
         b = CLOSED_BITS;
      end else begin
         b = oval_bits(e);
         if (link && e >= pc && e <= pc + 3'd2) begin
            b = b | pat;
         end
      end
      return b;
   endfunction

endpackage

// ----- design/led_eye_animation_sequencer.sv -----
// An accepted transaction is registered and then evaluated; a frame that it yields
// is registered once the output is free, and its first column then appears on rsp.
// Throughput: one transaction per cycle when no frame results; a frame occupies the
// output for 14 beats, the next frame-producing transaction waits for its last beat.
// Reset: synchronous, active high; clears state and loads the default durations.
`timescale 1ns / 1ps

module led_eye_animation_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lea_pkg::time_type       req_now_ms,
   input  logic                    req_link_up,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output lea_pkg::col_type        rsp_column_index,
   output lea_pkg::pixels_type     rsp_column_bits,
   output logic                    rsp_frame_last,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [lea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  lea_pkg::dur_type        csr_data
);
   import lea_pkg::*;

   dur_type long_open_ff, blink_closed_ff, short_open_ff, look_hold_ff, center_hold_ff;

   logic     in_valid_ff;
   time_type in_now_ff;
   logic     in_link_ff;

   time_type start_ff;
   step_type step_ff;
   logic     prev_link_ff;
   logic     known_ff;

   logic     em_valid_ff;
   logic     em_link_ff;
   step_type em_step_ff;
   col_type  col_ff;

   logic     changed;
   step_type len;
   step_type cur_step;
   step_type next_step;
   dur_type  dur;
   time_type elapsed;
   logic     expired;
   logic     need_emit;
   logic     emit_free;
   logic     eval_fire;
   logic     rsp_fire;

   assign csr_ready = 1'b1;

   always_comb begin
      changed = !known_ff || (in_link_ff != prev_link_ff);
      len = in_link_ff ? LOOK_STEPS : BLINK_LEN;
      cur_step = (step_ff < len) ? step_ff : 3'd0;
      if (in_link_ff) begin
         dur = (cur_step == 3'd1 || cur_step == 3'd3) ? center_hold_ff : look_hold_ff;
      end else begin
         case (cur_step)
            3'd1, 3'd3: dur = blink_closed_ff;
            3'd2:       dur = short_open_ff;
            default:    dur = long_open_ff;
         endcase
      end
      elapsed = in_now_ff - start_ff;
      expired = elapsed >= {{(TIME_W-DUR_W){1'b0}}, dur};
      next_step = (cur_step + 3'd1 >= len) ? 3'd0 : cur_step + 3'd1;
      need_emit = changed || expired;
      rsp_fire = em_valid_ff && rsp_ready;
      emit_free = !em_valid_ff || (rsp_ready && col_ff == LAST_COL);
      eval_fire = in_valid_ff && (!need_emit || emit_free);
      req_ready = !in_valid_ff || eval_fire;
   end

   assign rsp_valid = em_valid_ff;
   assign rsp_column_index = col_ff;
   assign rsp_column_bits = column_pattern(em_link_ff, em_step_ff, col_ff);
   assign rsp_frame_last = (col_ff == LAST_COL);

   always_ff @(posedge clock) begin
      if (reset) begin
         long_open_ff <= LONG_OPEN_RESET;
         blink_closed_ff <= BLINK_CLOSED_RESET;
         short_open_ff <= SHORT_OPEN_RESET;
         look_hold_ff <= LOOK_HOLD_RESET;
         center_hold_ff <= CENTER_HOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LONG_OPEN:    long_open_ff <= csr_data;
            REG_BLINK_CLOSED: blink_closed_ff <= csr_data;
            REG_SHORT_OPEN:   short_open_ff <= csr_data;
            REG_LOOK_HOLD:    look_hold_ff <= csr_data;
            REG_CENTER_HOLD:  center_hold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff <= req_now_ms;
         in_link_ff <= req_link_up;
      end
      if (em_valid_ff == 1'b0 || emit_free) begin
         if (eval_fire && need_emit) begin
            em_link_ff <= in_link_ff;
            em_step_ff <= changed ? 3'd0 : next_step;
         end
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         start_ff <= '0;
         step_ff <= '0;
         prev_link_ff <= 1'b0;
         known_ff <= 1'b0;
         em_valid_ff <= 1'b0;
         col_ff <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (eval_fire && need_emit) begin
            start_ff <= in_now_ff;
            known_ff <= 1'b1;
            prev_link_ff <= in_link_ff;
            step_ff <= changed ? 3'd0 : next_step;
            em_valid_ff <= 1'b1;
            col_ff <= '0;
         end else if (rsp_fire) begin
            if (col_ff == LAST_COL) begin
               em_valid_ff <= 1'b0;
               col_ff <= '0;
            end else begin
               col_ff <= col_ff + 4'd1;
            end
         end
      end
   end

endmodule

// ----- design/lea_checker.sv -----
`timescale 1ns / 1ps

module lea_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input lea_pkg::col_type        rsp_column_index,
   input lea_pkg::pixels_type     rsp_column_bits,
   input logic                    rsp_frame_last
);
   import lea_pkg::*;

   a_last_marks_col13: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_frame_last == (rsp_column_index == LAST_COL)))
      else $error("frame_last does not match column 13");

   a_cols_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_frame_last |=>
         rsp_valid && rsp_column_index == $past(rsp_column_index) + 4'd1)
      else $error("columns of a frame not consecutive");

   a_frame_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_column_index == '0)
      else $error("frame did not start at column 0");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_column_index) && $stable(rsp_column_bits))
      else $error("stalled result changed");

endmodule

bind led_eye_animation_sequencer lea_checker u_lea_checker (.*);

// ----- tb/sv/led_eye_animation_sequencer_test.sv -----
`timescale 1ns / 1ps

module led_eye_animation_sequencer_test;

   import lea_pkg::*;

   localparam int NUM_COLS = 14;
   localparam int NUM_DIRECTED = 22;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_5 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

   localparam pixels_type OVAL [7] = '{8'h3C, 8'h42, 8'h81, 8'h81, 8'h81, 8'h42, 8'h3C};

   typedef enum logic [2:0] {
      FACE_OPEN,
      FACE_SHUT,
      FACE_LEFT,
      FACE_CENTER,
      FACE_RIGHT
   } face_type;

   typedef struct packed {
      col_type    index;
      pixels_type bits;
      logic       last;
   } column_beat_type;

   typedef struct packed {
      time_type now;
      logic     link;
      logic     typed;
      logic     shows;
      face_type face;
   } tick_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   time_type   req_now_ms = '0;
   logic       req_link_up = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   col_type    rsp_column_index;
   pixels_type rsp_column_bits;
   logic       rsp_frame_last;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   dur_type    csr_data = '0;

   // durations mirrored from the register writes
   dur_type hold_long_open = LONG_OPEN_RESET;
   dur_type hold_blink_closed = BLINK_CLOSED_RESET;
   dur_type hold_short_open = SHORT_OPEN_RESET;
   dur_type hold_look = LOOK_HOLD_RESET;
   dur_type hold_center = CENTER_HOLD_RESET;

   // animation state
   time_type mark_time = '0;
   step_type phase_step = '0;
   logic     last_link = 1'b0;
   logic     link_seen = 1'b0;

   column_beat_type pending_columns [$];
   int       mismatches = 0;
   int       quiet_cycles = 0;
   bit       no_idle = 1'b0;
   time_type cur_now = '0;
   logic     cur_link = 1'b0;

   tick_row_type directed_rows [NUM_DIRECTED] = '{
      '{32'd0,          1'b0, 1'b1, 1'b1, FACE_OPEN},
      '{32'd1999,       1'b0, 1'b1, 1'b0, FACE_OPEN},
      '{32'd2000,       1'b0, 1'b1, 1'b1, FACE_SHUT},
      '{32'd2099,       1'b0, 1'b1, 1'b0, FACE_OPEN},
      '{32'd2100,       1'b0, 1'b1, 1'b1, FACE_OPEN},
      '{32'd2250,       1'b0, 1'b1, 1'b1, FACE_SHUT},
      '{32'd2350,       1'b0, 1'b1, 1'b1, FACE_OPEN},
      '{32'd4350,       1'b0, 1'b1, 1'b1, FACE_OPEN},
      '{32'd4350,       1'b1, 1'b1, 1'b1, FACE_LEFT},
      '{32'd4849,       1'b1, 1'b1, 1'b0, FACE_OPEN},
      '{32'd4850,       1'b1, 1'b1, 1'b1, FACE_CENTER},
      '{32'd5050,       1'b1, 1'b1, 1'b1, FACE_RIGHT},
      '{32'd5550,       1'b1, 1'b1, 1'b1, FACE_CENTER},
      '{32'd5750,       1'b1, 1'b1, 1'b1, FACE_LEFT},
      '{32'hFFFF_FF00,  1'b1, 1'b0, 1'b0, FACE_OPEN},
      '{32'hFFFF_FFFF,  1'b1, 1'b0, 1'b0, FACE_OPEN},
      '{32'h0000_00F0,  1'b1, 1'b0, 1'b0, FACE_OPEN},
      '{32'h0000_01F3,  1'b1, 1'b0, 1'b0, FACE_OPEN},
      '{32'h0000_01F3,  1'b0, 1'b1, 1'b1, FACE_OPEN},
      '{32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, FACE_OPEN},
      '{32'd0,          1'b1, 1'b1, 1'b1, FACE_LEFT},
      '{32'd0,          1'b0, 1'b1, 1'b1, FACE_OPEN}
   };

   led_eye_animation_sequencer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_now_ms       (req_now_ms),
      .req_link_up      (req_link_up),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_column_index (rsp_column_index),
      .rsp_column_bits  (rsp_column_bits),
      .rsp_frame_last   (rsp_frame_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic face_type face_of(logic link, step_type s);
      if (link) begin
         return (s == 3'd0) ? FACE_LEFT : (s == 3'd2) ? FACE_RIGHT : FACE_CENTER;
      end
      return (s == 3'd1 || s == 3'd3) ? FACE_SHUT : FACE_OPEN;
   endfunction

   function automatic dur_type hold_of(logic link, step_type s);
      if (link) begin
         return (s == 3'd1 || s == 3'd3) ? hold_center : hold_look;
      end
      case (s)
         3'd1, 3'd3: return hold_blink_closed;
         3'd2:       return hold_short_open;
         default:    return hold_long_open;
      endcase
   endfunction

   function automatic pixels_type face_column(face_type f, int col);
      int e;
      pixels_type b;
      e = (col < 7) ? col : col - 7;
      if (f == FACE_SHUT) begin
         return CLOSED_BITS;
      end
      b = OVAL[e];
      case (f)
         FACE_LEFT:   if (e >= 1 && e <= 3) b = b | PUPIL_UP;
         FACE_CENTER: if (e >= 2 && e <= 4) b = b | PUPIL_MID;
         FACE_RIGHT:  if (e >= 4 && e <= 6) b = b | PUPIL_UP;
         default: ;
      endcase
      return b;
   endfunction

   task automatic advance_animation(input time_type now, input logic link,
                                    output logic shows, output face_type face);
      step_type len;
      step_type s;
      shows = 1'b0;
      face = FACE_OPEN;
      if (!link_seen || link != last_link) begin
         link_seen = 1'b1;
         last_link = link;
         mark_time = now;
         phase_step = '0;
         face = face_of(link, '0);
         shows = 1'b1;
      end else begin
         len = link ? LOOK_STEPS : BLINK_LEN;
         s = (phase_step < len) ? phase_step : '0;
         if (time_type'(now - mark_time) >= time_type'(hold_of(link, s))) begin
            mark_time = now;
            s = s + 3'd1;
            if (s >= len) begin
               s = '0;
            end
            phase_step = s;
            face = face_of(link, s);
            shows = 1'b1;
         end
      end
   endtask

   task automatic queue_frame(input face_type face);
      column_beat_type beat;
      for (int c = 0; c < NUM_COLS; c++) begin
         beat.index = col_type'(c);
         beat.bits = face_column(face, c);
         beat.last = (c == NUM_COLS - 1);
         pending_columns.push_back(beat);
      end
   endtask

   task automatic send_tick(input time_type now, input logic link);
      while (!no_idle && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_ms <= now;
      req_link_up <= link;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_tick(input tick_row_type row);
      logic shows;
      face_type face;
      send_tick(row.now, row.link);
      advance_animation(row.now, row.link, shows, face);
      if (row.typed) begin
         if (row.shows) queue_frame(row.face);
      end else if (shows) begin
         queue_frame(face);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input dur_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LONG_OPEN:    hold_long_open = data;
         REG_BLINK_CLOSED: hold_blink_closed = data;
         REG_SHORT_OPEN:   hold_short_open = data;
         REG_LOOK_HOLD:    hold_look = data;
         REG_CENTER_HOLD:  hold_center = data;
         default: ;
      endcase
   endtask

   task automatic configure(input dur_type long_open, input dur_type closed,
                            input dur_type short_open, input dur_type look,
                            input dur_type center, input dur_type spare);
      write_reg(REG_LONG_OPEN, long_open);
      write_reg(REG_BLINK_CLOSED, closed);
      write_reg(REG_SHORT_OPEN, short_open);
      write_reg(REG_LOOK_HOLD, look);
      write_reg(REG_CENTER_HOLD, center);
      write_reg(REG_SPARE_5, spare);
      write_reg(REG_SPARE_6, spare);
      write_reg(REG_SPARE_7, spare);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      while (pending_columns.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_ticks(input int count, input int quiet);
      int unsigned span;
      int unsigned r;
      tick_row_type row;
      span = hold_long_open;
      if (hold_blink_closed > span) span = hold_blink_closed;
      if (hold_short_open > span) span = hold_short_open;
      if (hold_look > span) span = hold_look;
      if (hold_center > span) span = hold_center;
      span = 2 * span + 2;
      for (int i = 0; i < count; i++) begin
         no_idle = (i < quiet);
         r = $urandom_range(0, 99);
         if (r < 4) begin
            cur_now = $urandom;
         end else begin
            if (r < 12) cur_link = ~cur_link;
            cur_now = cur_now + time_type'($urandom_range(0, span));
         end
         row = '{cur_now, cur_link, 1'b0, 1'b0, FACE_OPEN};
         run_tick(row);
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      drain();
   endtask

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= 22);
   end

   always @(posedge clock) begin
      column_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_columns.size() == 0) begin
            $error("unexpected transaction: column_index %0d column_bits %02h",
                   rsp_column_index, rsp_column_bits);
            mismatches++;
         end else begin
            want = pending_columns.pop_front();
            if (rsp_column_index !== want.index) begin
               $error("column_index expected %0d actual %0d", want.index, rsp_column_index);
               mismatches++;
            end
            if (rsp_column_bits !== want.bits) begin
               $error("column_bits expected %02h actual %02h", want.bits, rsp_column_bits);
               mismatches++;
            end
            if (rsp_frame_last !== want.last) begin
               $error("frame_last expected %0d actual %0d", want.last, rsp_frame_last);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) begin
         run_tick(directed_rows[i]);
      end
      req_valid <= 1'b0;
      drain();
      cur_now = directed_rows[NUM_DIRECTED-1].now;
      cur_link = directed_rows[NUM_DIRECTED-1].link;

      configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      random_ticks(40, 0);

      configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      random_ticks(60, 0);

      configure(dur_type'($urandom_range(1, 24)), dur_type'($urandom_range(1, 24)),
                dur_type'($urandom_range(1, 24)), dur_type'($urandom_range(1, 24)),
                dur_type'($urandom_range(1, 24)), dur_type'($urandom_range(0, 65535)));
      random_ticks(160, 60);

      configure(dur_type'($urandom_range(0, 65535)), dur_type'($urandom_range(0, 65535)),
                dur_type'($urandom_range(0, 65535)), dur_type'($urandom_range(0, 65535)),
                dur_type'($urandom_range(0, 65535)), dur_type'($urandom_range(0, 65535)));
      random_ticks(80, 0);

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/lea_pkg.sv
design/led_eye_animation_sequencer.sv
design/lea_checker.sv
tb/sv/led_eye_animation_sequencer_test.sv
